[src/trb_transfer_ring_producer_macros.svh]
// Assertion helpers for the ring producer RTL, used by the back end.
`ifndef TRB_TRANSFER_RING_PRODUCER_MACROS_SVH
`define TRB_TRANSFER_RING_PRODUCER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define TRB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("trb assertion failed");

// Next-cycle implication, checked out of reset.
`define TRB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("trb assertion failed");

`endif

[src/trb_pkg.sv]
`default_nettype none

package trb_pkg;

	// Request kinds
	localparam logic [1:0] REQ_CONTROL = 2'd0;
	localparam logic [1:0] REQ_NORMAL  = 2'd1;
	localparam logic [1:0] REQ_RESET   = 2'd2;

	// TRB type codes, control bits 15:10
	localparam logic [5:0] TRB_TYPE_NORMAL = 6'd1;
	localparam logic [5:0] TRB_TYPE_SETUP  = 6'd2;
	localparam logic [5:0] TRB_TYPE_DATA   = 6'd3;
	localparam logic [5:0] TRB_TYPE_STATUS = 6'd4;
	localparam logic [5:0] TRB_TYPE_LINK   = 6'd6;

	localparam logic [31:0] BIT_TC  = 32'h0000_0002;
	localparam logic [31:0] BIT_ISP = 32'h0000_0004;
	localparam logic [31:0] BIT_IOC = 32'h0000_0020;
	localparam logic [31:0] BIT_IDT = 32'h0000_0040;
	localparam logic [31:0] BIT_DIR = 32'h0001_0000;

	localparam logic [1:0] TRT_NO_DATA = 2'd0;
	localparam logic [1:0] TRT_OUT     = 2'd2;
	localparam logic [1:0] TRT_IN      = 2'd3;

	localparam logic [31:0] SETUP_LEN = 32'd8;

	// Command queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	typedef struct packed {
		logic [1:0]  kind;
		logic        rd;        // device-to-host
		logic        has_data;  // saturated length is nonzero
		logic [15:0] len;       // saturated length
		logic [63:0] setup;
	} trb_cmd_t;

	function automatic logic [31:0] type_bits(input logic [5:0] t);
		type_bits = {16'b0, t, 10'b0};
	endfunction

endpackage

`default_nettype wire

[src/trb_transfer_ring_producer.sv]
// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+-------------------------------------------
// input     | in        | in_valid / in_stall  | req_type, setup_packet, transfer_length
// output    | out       | out_valid/ out_stall | entry_index, trb_parameter, status_dword,
//           |           |                      | trb_control, last_write
// config    | in        | cfg_we               | cfg_index, cfg_data
//
// Each TRB write is one output beat, one per cycle while out_stall is low. A control
// request takes two or three beats, a normal request or ring reset one, plus one beat
// for the link write when the ring wraps; the back-end sequencer sets this figure.
// Reset is asynchronous and clears index to 0 and producer cycle to 1; no clearing pass.
// A two-entry command queue lets the front keep taking input beats while out_stall
// holds the back end; requests of the unused kind are dropped in the front.
`default_nettype none

module trb_transfer_ring_producer #(
	parameter int RING_ENTRIES     = 256,
	parameter int BUFFER_MAX_BYTES = 4096
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          cfg_we,
	input  wire  [0:0]   cfg_index,
	input  wire  [31:0]  cfg_data,
	input  wire          in_valid,
	output logic         in_stall,
	input  wire  [1:0]   req_type,
	input  wire  [63:0]  setup_packet,
	input  wire  [15:0]  transfer_length,
	output logic         out_valid,
	input  wire          out_stall,
	output logic [7:0]   entry_index,
	output logic [63:0]  trb_parameter,
	output logic [31:0]  status_dword,
	output logic [31:0]  trb_control,
	output logic         last_write
);
	import trb_pkg::*;

	localparam logic [0:0] REG_RING_BASE = 1'b0;
	localparam logic [0:0] REG_BUF_ADDR  = 1'b1;

	logic [31:0] ring_base_q;
	logic [31:0] buffer_address_q;

	logic        f_push;
	trb_cmd_t    f_cmd;
	logic        q_ready;
	logic        q_valid;
	trb_cmd_t    q_head;
	logic        q_pop;

	// Configuration registers; the user writes them only while the block is quiet (not enforced)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_base_q      <= 32'd0;
			buffer_address_q <= 32'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RING_BASE: ring_base_q      <= cfg_data;
				REG_BUF_ADDR:  buffer_address_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front: accept and classify requests
	trb_front #(
		.BUFFER_MAX_BYTES(BUFFER_MAX_BYTES)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.req_type        (req_type),
		.setup_packet    (setup_packet),
		.transfer_length (transfer_length),
		.q_push          (f_push),
		.q_cmd           (f_cmd),
		.q_ready         (q_ready)
	);

	// Decouple front and back
	trb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (f_push),
		.push_cmd (f_cmd),
		.ready    (q_ready),
		.valid    (q_valid),
		.head_cmd (q_head),
		.pop      (q_pop)
	);

	// Back: walk the TRB sequence, track index and cycle, drive the output beat
	trb_back #(
		.RING_ENTRIES(RING_ENTRIES)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.ring_base      (ring_base_q),
		.buffer_address (buffer_address_q),
		.q_valid        (q_valid),
		.q_cmd          (q_head),
		.q_pop          (q_pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.entry_index    (entry_index),
		.trb_parameter  (trb_parameter),
		.status_dword   (status_dword),
		.trb_control    (trb_control),
		.last_write     (last_write)
	);

endmodule

`default_nettype wire

[src/trb_front.sv]
`default_nettype none

module trb_front #(
	parameter int BUFFER_MAX_BYTES = 4096
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  wire  [1:0]          req_type,
	input  wire  [63:0]         setup_packet,
	input  wire  [15:0]         transfer_length,
	output logic                q_push,
	output trb_pkg::trb_cmd_t   q_cmd,
	input  wire                 q_ready
);
	import trb_pkg::*;

	localparam logic [15:0] MAX_LEN = 16'(BUFFER_MAX_BYTES);

	logic      valid_s1;
	trb_cmd_t  cmd_s1;
	trb_cmd_t  cmd_c;
	logic      keep_c;
	logic      accept;

	// Classify: saturate length, pull direction from bmRequestType bit 7
	always_comb begin
		cmd_c.kind     = req_type;
		cmd_c.setup    = setup_packet;
		cmd_c.len      = (transfer_length > MAX_LEN) ? MAX_LEN : transfer_length;
		cmd_c.has_data = (cmd_c.len != 16'd0);
		cmd_c.rd       = setup_packet[7];
		keep_c         = req_type inside {REQ_CONTROL, REQ_NORMAL, REQ_RESET};
	end

	assign in_stall = valid_s1 && !q_ready;
	assign accept   = in_valid && !in_stall;
	assign q_push   = valid_s1 && q_ready;
	assign q_cmd    = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= keep_c;   // drop unused request kinds
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_c;
		end
	end

endmodule

`default_nettype wire

[src/trb_queue.sv]
`default_nettype none

module trb_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  trb_pkg::trb_cmd_t   push_cmd,
	output logic                ready,
	output logic                valid,
	output trb_pkg::trb_cmd_t   head_cmd,
	input  wire                 pop
);
	import trb_pkg::*;

	trb_cmd_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic                do_push;
	logic                do_pop;

	assign ready    = (cnt_q != QCNT_W'(QDEPTH));
	assign valid    = (cnt_q != '0);
	assign head_cmd = mem_q[rd_ptr_q];
	assign do_push  = push && ready;
	assign do_pop   = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

[src/trb_back.sv]
`default_nettype none
`include "trb_transfer_ring_producer_macros.svh"

module trb_back #(
	parameter int RING_ENTRIES = 256
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire  [31:0]         ring_base,
	input  wire  [31:0]         buffer_address,
	input  wire                 q_valid,
	input  trb_pkg::trb_cmd_t   q_cmd,
	output logic                q_pop,
	output logic                out_valid,
	input  wire                 out_stall,
	output logic [7:0]          entry_index,
	output logic [63:0]         trb_parameter,
	output logic [31:0]         status_dword,
	output logic [31:0]         trb_control,
	output logic                last_write
);
	import trb_pkg::*;

	localparam int IDX_W = $clog2(RING_ENTRIES);
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(RING_ENTRIES - 1);

	typedef enum logic [6:0] {
		PH_IDLE   = 7'b000_0001,
		PH_SETUP  = 7'b000_0010,
		PH_DATA   = 7'b000_0100,
		PH_STATUS = 7'b000_1000,
		PH_NORMAL = 7'b001_0000,
		PH_RESET  = 7'b010_0000,
		PH_LINK   = 7'b100_0000
	} phase_t;

	phase_t             phase_q;
	phase_t             ret_q;
	trb_cmd_t           cmd_q;
	logic [IDX_W-1:0]   idx_q;
	logic               cyc_q;

	logic               out_valid_q;
	logic [IDX_W-1:0]   slot_q;
	logic [63:0]        param_q;
	logic [31:0]        status_q;
	logic [31:0]        ctrl_q;
	logic               last_q;

	logic               advance;
	logic               emit;
	logic               is_push;
	logic [IDX_W-1:0]   slot_c;
	logic [IDX_W+7:0]   slot_ext;
	logic [63:0]        param_c;
	logic [31:0]        status_c;
	logic [31:0]        ctrl_c;
	logic [1:0]         trt_c;
	phase_t             succ_c;
	phase_t             after_c;
	phase_t             first_c;
	logic               final_c;
	logic [IDX_W-1:0]   idx_inc;
	logic               wrap_c;

	assign advance = !out_valid_q || !out_stall;
	assign idx_inc = idx_q + 1'b1;
	assign wrap_c  = (idx_inc == LAST_SLOT);
	assign trt_c   = !cmd_q.has_data ? TRT_NO_DATA : (cmd_q.rd ? TRT_IN : TRT_OUT);

	always_comb begin
		emit     = 1'b1;
		is_push  = 1'b1;
		slot_c   = idx_q;
		param_c  = 64'd0;
		status_c = 32'd0;
		ctrl_c   = 32'd0;
		succ_c   = PH_IDLE;
		case (phase_q)
			PH_SETUP: begin
				param_c  = cmd_q.setup;
				status_c = SETUP_LEN;
				ctrl_c   = type_bits(TRB_TYPE_SETUP) | BIT_IDT | {14'b0, trt_c, 16'b0};
				succ_c   = cmd_q.has_data ? PH_DATA : PH_STATUS;
			end
			PH_DATA: begin
				param_c  = {32'b0, buffer_address};
				status_c = {16'b0, cmd_q.len};
				ctrl_c   = type_bits(TRB_TYPE_DATA) | (cmd_q.rd ? BIT_DIR : 32'd0);
				succ_c   = PH_STATUS;
			end
			PH_STATUS: begin
				ctrl_c = type_bits(TRB_TYPE_STATUS) | BIT_IOC |
				         ((!cmd_q.rd && cmd_q.has_data) ? BIT_DIR : 32'd0);
			end
			PH_NORMAL: begin
				param_c  = {32'b0, buffer_address};
				status_c = {16'b0, cmd_q.len};
				ctrl_c   = type_bits(TRB_TYPE_NORMAL) | BIT_IOC | BIT_ISP;
			end
			PH_RESET: begin
				is_push = 1'b0;
				slot_c  = LAST_SLOT;
				param_c = {32'b0, ring_base};
				ctrl_c  = type_bits(TRB_TYPE_LINK) | BIT_TC;
			end
			PH_LINK: begin
				is_push = 1'b0;
				slot_c  = LAST_SLOT;
				param_c = {32'b0, ring_base};
				ctrl_c  = type_bits(TRB_TYPE_LINK) | BIT_TC;
				succ_c  = ret_q;
			end
			default: begin
				emit    = 1'b0;
				is_push = 1'b0;
			end
		endcase
		// Pushes and the wrap link both carry the live producer cycle
		if (is_push || phase_q == PH_LINK) begin
			ctrl_c[0] = cyc_q;
		end
	end

	always_comb begin
		case (q_cmd.kind)
			REQ_CONTROL: first_c = PH_SETUP;
			REQ_NORMAL:  first_c = PH_NORMAL;
			default:     first_c = PH_RESET;
		endcase
	end

	assign after_c  = (is_push && wrap_c) ? PH_LINK : succ_c;
	assign final_c  = (after_c == PH_IDLE);
	assign q_pop    = q_valid && (!emit || (advance && final_c));
	assign slot_ext = {8'b0, slot_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			ret_q       <= PH_IDLE;
			idx_q       <= '0;
			cyc_q       <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (!emit) begin
				phase_q <= q_valid ? first_c : PH_IDLE;
			end else if (advance) begin
				if (final_c) begin
					phase_q <= q_valid ? first_c : PH_IDLE;
				end else begin
					phase_q <= after_c;
				end
				if (is_push && wrap_c) begin
					ret_q <= succ_c;
				end
				if (is_push) begin
					idx_q <= wrap_c ? '0 : idx_inc;
				end else if (phase_q == PH_LINK) begin
					cyc_q <= ~cyc_q;
				end else begin
					idx_q <= '0;
					cyc_q <= 1'b1;
				end
			end
			if (advance) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
		end
		if (advance && emit) begin
			slot_q   <= slot_c;
			param_q  <= param_c;
			status_q <= status_c;
			ctrl_q   <= ctrl_c;
			last_q   <= final_c;
		end
	end

	assign out_valid     = out_valid_q;
	assign entry_index   = slot_ext[7:0];
	assign trb_parameter = param_q;
	assign status_dword  = status_q;
	assign trb_control   = ctrl_q;
	assign last_write    = last_q;

	`TRB_ASSERT_IMP(a_link_slot, clk, arst_n,
		out_valid_q && (ctrl_q[15:10] == TRB_TYPE_LINK), slot_q == LAST_SLOT)
	`TRB_ASSERT_NXT(a_wrap_resets_idx, clk, arst_n,
		advance && (phase_q == PH_LINK), (idx_q == '0) && (cyc_q != $past(cyc_q)))
	`TRB_ASSERT_IMP(a_idx_below_link, clk, arst_n,
		phase_q != PH_LINK, idx_q != LAST_SLOT)
	`TRB_ASSERT_IMP(a_pop_needs_data, clk, arst_n, q_pop, q_valid)

endmodule

`default_nettype wire

[tb/trb_transfer_ring_producer_test.sv]
`timescale 1ns / 1ps

module trb_transfer_ring_producer_test;
	import trb_pkg::*;

	localparam int RING_ENTRIES     = 256;
	localparam int BUFFER_MAX_BYTES = 4096;

	// Request kind the block drops without a write
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	// Register indexes of the config port
	localparam logic [0:0] CFG_RING_BASE   = 1'b0;
	localparam logic [0:0] CFG_BUFFER_ADDR = 1'b1;

	localparam int SETTLE_CYCLES = 24;       // drain of the two-entry queue and back end
	localparam int LONG_HOLD     = 300;      // receiver hold-off under pressure
	localparam int TIMEOUT_NS    = 3_000_000;

	typedef struct {
		logic [1:0]  kind;
		logic [63:0] setup;
		logic [15:0] len;
	} ring_req_t;

	typedef struct {
		logic [7:0]  slot;
		logic [63:0] param;
		logic [31:0] status;
		logic [31:0] control;
		logic        last;
	} trb_write_t;

	logic        clk;
	logic        arst_n          = 1'b0;
	logic        cfg_we          = 1'b0;
	logic [0:0]  cfg_index       = CFG_RING_BASE;
	logic [31:0] cfg_data        = 32'd0;
	logic        in_valid        = 1'b0;
	logic        in_stall;
	logic [1:0]  req_type        = REQ_CONTROL;
	logic [63:0] setup_packet    = 64'd0;
	logic [15:0] transfer_length = 16'd0;
	logic        out_valid;
	logic        out_stall       = 1'b0;
	logic [7:0]  entry_index;
	logic [63:0] trb_parameter;
	logic [31:0] status_dword;
	logic [31:0] trb_control;
	logic        last_write;

	trb_transfer_ring_producer #(
		.RING_ENTRIES     (RING_ENTRIES),
		.BUFFER_MAX_BYTES (BUFFER_MAX_BYTES)
	) u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.req_type        (req_type),
		.setup_packet    (setup_packet),
		.transfer_length (transfer_length),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.entry_index     (entry_index),
		.trb_parameter   (trb_parameter),
		.status_dword    (status_dword),
		.trb_control     (trb_control),
		.last_write      (last_write)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Ring shadow: slot, producer cycle and the two registers
	int          ring_slot  = 0;
	logic        ring_cycle = 1'b1;
	logic [31:0] ring_base_reg   = 32'd0;
	logic [31:0] buffer_addr_reg = 32'd0;

	trb_write_t trb_expected[$];
	ring_req_t  pending_reqs[$];

	int queued_count = 0;     // requests handed to the driver
	int sent_count   = 0;     // input beats accepted by the block
	int fail_count   = 0;

	// Pacing knobs, changed only between phases
	int  send_gap_max = 15;
	int  recv_gap_max = 15;
	bit  long_hold_armed = 1'b0;
	bit  long_hold_done  = 1'b0;
	int  hold_left  = 0;
	int  send_wait  = 0;
	int  recv_wait  = 0;
	logic in_beat  = 1'b0;
	logic out_beat = 1'b0;

	function automatic logic [31:0] type_field(input logic [5:0] code);
		return {16'd0, code, 10'd0};
	endfunction

	// Record one write as it should appear on the output channel
	task automatic record_trb(input int slot, input logic [63:0] param,
			input logic [31:0] status, input logic [31:0] control);
		trb_write_t t;
		t.slot    = 8'(slot);
		t.param   = param;
		t.status  = status;
		t.control = control;
		t.last    = 1'b0;
		trb_expected.push_back(t);
	endtask

	// Stamp the cycle, advance the slot, and wrap through the link slot
	task automatic push_trb(input logic [63:0] param, input logic [31:0] status,
			input logic [31:0] control);
		record_trb(ring_slot, param, status, {control[31:1], ring_cycle});
		ring_slot++;
		if (ring_slot >= RING_ENTRIES - 1) begin
			record_trb(RING_ENTRIES - 1, {32'd0, ring_base_reg}, 32'd0,
				type_field(TRB_TYPE_LINK) | BIT_TC | {31'd0, ring_cycle});
			ring_slot  = 0;
			ring_cycle = ~ring_cycle;
		end
	endtask

	task automatic predict_trbs(input ring_req_t r);
		int         first;
		logic       rd;
		logic [15:0] len;
		logic [1:0] trt;
		trb_write_t t;
		first = trb_expected.size();
		rd    = r.setup[7];
		len   = (r.len > 16'(BUFFER_MAX_BYTES)) ? 16'(BUFFER_MAX_BYTES) : r.len;
		trt   = (len == 16'd0) ? TRT_NO_DATA : (rd ? TRT_IN : TRT_OUT);
		case (r.kind)
			REQ_CONTROL: begin
				push_trb(r.setup, SETUP_LEN,
					type_field(TRB_TYPE_SETUP) | BIT_IDT | {14'd0, trt, 16'd0});
				if (len != 16'd0)
					push_trb({32'd0, buffer_addr_reg}, {16'd0, len},
						type_field(TRB_TYPE_DATA) | (rd ? BIT_DIR : 32'd0));
				push_trb(64'd0, 32'd0, type_field(TRB_TYPE_STATUS) | BIT_IOC |
					((!rd && len != 16'd0) ? BIT_DIR : 32'd0));
			end
			REQ_NORMAL: begin
				push_trb({32'd0, buffer_addr_reg}, {16'd0, len},
					type_field(TRB_TYPE_NORMAL) | BIT_IOC | BIT_ISP);
			end
			REQ_RESET: begin
				// Link rewrite carries cycle 0; the ring restarts at slot 0, cycle 1
				record_trb(RING_ENTRIES - 1, {32'd0, ring_base_reg}, 32'd0,
					type_field(TRB_TYPE_LINK) | BIT_TC);
				ring_slot  = 0;
				ring_cycle = 1'b1;
			end
			default: ;
		endcase
		if (trb_expected.size() > first) begin
			t = trb_expected.pop_back();
			t.last = 1'b1;
			trb_expected.push_back(t);
		end
	endtask

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	// Predict on each input beat, compare each output beat with the oldest expectation
	always @(posedge clk) begin : beat_check
		ring_req_t  r;
		trb_write_t want;
		if (arst_n) begin
			in_beat  <= in_valid && !in_stall;
			out_beat <= out_valid && !out_stall;
			if (in_valid && !in_stall) begin
				r.kind  = req_type;
				r.setup = setup_packet;
				r.len   = transfer_length;
				predict_trbs(r);
				sent_count++;
			end
			if (out_valid && !out_stall) begin
				if (trb_expected.size() == 0) begin
					$error("unexpected TRB write at entry_index 0x%0h", entry_index);
					fail_count++;
				end else begin
					want = trb_expected.pop_front();
					check_field("entry_index", {56'd0, want.slot}, {56'd0, entry_index});
					check_field("trb_parameter", want.param, trb_parameter);
					check_field("status_dword", {32'd0, want.status}, {32'd0, status_dword});
					check_field("trb_control", {32'd0, want.control}, {32'd0, trb_control});
					check_field("last_write", {63'd0, want.last}, {63'd0, last_write});
				end
			end
		end
	end

	// Sender: hold a stalled beat, wait the drawn gap, then offer the next request
	always @(negedge clk) begin : req_drive
		ring_req_t next_req;
		if (arst_n && (!in_valid || in_beat)) begin
			if (send_wait > 0) begin
				in_valid  <= 1'b0;
				send_wait <= send_wait - 1;
			end else if (pending_reqs.size() > 0) begin
				next_req = pending_reqs.pop_front();
				req_type        <= next_req.kind;
				setup_packet    <= next_req.setup;
				transfer_length <= next_req.len;
				in_valid        <= 1'b1;
				send_wait       <= $urandom_range(0, send_gap_max);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: long hold-off when armed, else a drawn stall after every beat
	always @(negedge clk) begin : trb_accept
		int draw;
		if (arst_n) begin
			if (long_hold_armed && !long_hold_done) begin
				hold_left      <= LONG_HOLD;
				long_hold_done <= 1'b1;
				out_stall      <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else if (recv_wait > 0) begin
				recv_wait <= recv_wait - 1;
				out_stall <= 1'b1;
			end else if (out_beat) begin
				draw = $urandom_range(0, recv_gap_max);
				recv_wait <= (draw > 0) ? draw - 1 : 0;
				out_stall <= (draw > 0);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic write_reg(input logic [0:0] idx, input logic [31:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		if (idx == CFG_RING_BASE)
			ring_base_reg = value;
		else
			buffer_addr_reg = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_req(input logic [1:0] kind, input logic [63:0] setup,
			input logic [15:0] len);
		ring_req_t r;
		r.kind  = kind;
		r.setup = setup;
		r.len   = len;
		pending_reqs.push_back(r);
		queued_count++;
	endtask

	// Mostly control and normal requests; resets at the given rate, a little noise
	task automatic queue_random(input int count, input int reset_pct);
		int          pick;
		logic [1:0]  kind;
		logic [15:0] len;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < reset_pct)
				kind = REQ_RESET;
			else if (pick < 60)
				kind = REQ_CONTROL;
			else if (pick < 94)
				kind = REQ_NORMAL;
			else
				kind = REQ_UNUSED;
			case ($urandom_range(0, 7))
				0, 1:    len = 16'd0;
				2:       len = 16'($urandom_range(BUFFER_MAX_BYTES - 6, BUFFER_MAX_BYTES + 6));
				3:       len = 16'($urandom);
				default: len = 16'($urandom_range(1, 64));
			endcase
			queue_req(kind, {$urandom, $urandom}, len);
		end
	endtask

	// Pace a new phase; take effect on a rising edge so the driver sees stable knobs
	task automatic set_pacing(input int send_max, input int recv_max);
		@(posedge clk);
		send_gap_max = send_max;
		recv_gap_max = recv_max;
	endtask

	// Stop until every request is in and every write is out, then let the block settle
	task automatic wait_drained();
		while (!(sent_count == queued_count && trb_expected.size() == 0))
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: length edges, both directions, drop of the unused kind, resets
		write_reg(CFG_RING_BASE, 32'hFFFF_FFFF);
		write_reg(CFG_BUFFER_ADDR, 32'h0000_0000);
		set_pacing(15, 15);
		queue_req(REQ_CONTROL, 64'h0000_0000_0000_0000, 16'd0);
		queue_req(REQ_CONTROL, 64'h0000_0000_0000_0080, 16'd0);
		queue_req(REQ_CONTROL, 64'h0000_0000_0000_0000, 16'd1);
		queue_req(REQ_CONTROL, 64'hFFFF_FFFF_FFFF_FFFF, 16'd4096);
		queue_req(REQ_CONTROL, 64'hFFFF_FFFF_FFFF_FF7F, 16'd4097);
		queue_req(REQ_CONTROL, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
		queue_req(REQ_CONTROL, 64'h0000_0000_0000_0080, 16'd4095);
		queue_req(REQ_NORMAL, 64'h0, 16'd0);
		queue_req(REQ_NORMAL, 64'hFFFF_FFFF_FFFF_FFFF, 16'd4095);
		queue_req(REQ_NORMAL, 64'h0, 16'hFFFF);
		queue_req(REQ_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
		queue_req(REQ_UNUSED, 64'h0, 16'd0);
		queue_req(REQ_RESET, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
		queue_req(REQ_CONTROL, 64'h0000_0000_0000_0080, 16'd8);
		queue_req(REQ_RESET, 64'h0, 16'd0);
		queue_req(REQ_RESET, 64'h0, 16'd0);
		queue_req(REQ_NORMAL, 64'h0, 16'd4096);
		queue_req(REQ_CONTROL, 64'h5A5A_A5A5_0F0F_F0F0, 16'd4096);
		wait_drained();

		// Random, full idling on both sides; no resets so the ring wraps
		write_reg(CFG_RING_BASE, 32'h0000_0000);
		write_reg(CFG_BUFFER_ADDR, 32'hFFFF_FFFF);
		set_pacing(15, 15);
		queue_random(120, 0);
		wait_drained();

		// Pressure: sender back to back while the receiver holds off for a long stretch
		write_reg(CFG_RING_BASE, $urandom);
		write_reg(CFG_BUFFER_ADDR, $urandom);
		set_pacing(0, 3);
		long_hold_armed = 1'b1;
		queue_random(60, 0);
		wait_drained();

		// No idling at all
		write_reg(CFG_RING_BASE, $urandom);
		write_reg(CFG_BUFFER_ADDR, $urandom);
		set_pacing(0, 0);
		queue_random(100, 0);
		wait_drained();

		// Random idling again, with resets mixed in
		write_reg(CFG_RING_BASE, $urandom);
		write_reg(CFG_BUFFER_ADDR, $urandom);
		set_pacing(15, 15);
		queue_random(100, 4);
		wait_drained();

		if (fail_count == 0 && trb_expected.size() == 0)
			$display("trb_transfer_ring_producer: match");
		else
			$display("trb_transfer_ring_producer: mismatch");
		$finish;
	end

	// Stop a hung run
	initial begin
		#(TIMEOUT_NS);
		$display("trb_transfer_ring_producer: mismatch");
		$finish;
	end

endmodule
